/* hdl/lcdseq_pkg.sv */
// Package for the character LCD command sequencer.
// Holds the request and transfer types, controller/datapath command types and bus constants.
// No dependencies.
package lcdseq_pkg;

  typedef enum logic [2:0] {
    OP_INIT        = 3'd0,
    OP_CLEAR       = 3'd1,
    OP_CURSOR_OFF  = 3'd2,
    OP_GOTO        = 3'd3,
    OP_PUT_CHAR    = 3'd4,
    OP_BAR_GRAPH   = 3'd5,
    OP_CGRAM_START = 3'd6,
    OP_CGRAM_BYTE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_NIBBLE = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  typedef struct packed {
    op_t        operation;
    logic [4:0] column;
    logic [1:0] row;
    logic [7:0] char_code;
    logic [6:0] percent;
    logic [4:0] bar_cells;
  } lcd_req_t;

  typedef struct packed {
    kind_t      transfer_kind;
    logic [7:0] transfer_value;
    logic       last;
  } lcd_xfer_t;

  typedef enum logic [1:0] {
    VSEL_CONST = 2'd0,
    VSEL_GOTO  = 2'd1,
    VSEL_CODE  = 2'd2,
    VSEL_BAR   = 2'd3
  } vsel_t;

  typedef enum logic [2:0] {
    CUR_HOLD  = 3'd0,
    CUR_ZERO  = 3'd1,
    CUR_GOTO  = 3'd2,
    CUR_LINE2 = 3'd3,
    CUR_INC   = 3'd4
  } cur_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CLEAR,
    S_HOME,
    S_OFF,
    S_GOTO,
    S_CHAR,
    S_CHAR_DATA,
    S_BAR_MUL,
    S_BAR_DIV,
    S_BAR_CELL,
    S_BAR_DATA,
    S_CGRAM_START,
    S_CGRAM_BYTE
  } ctrl_state_t;

  typedef struct packed {
    logic       load_req;
    logic       emit;
    kind_t      kind;
    vsel_t      vsel;
    logic [7:0] value;
    logic       last;
    cur_op_t    cur_op;
    logic       bar_mul;
    logic       bar_div;
    logic       bar_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_wrap;
    logic bar_none;
    logic bar_more;
  } dp_status_t;

  localparam logic [7:0] NIB_EIGHT_BIT  = 8'h03;
  localparam logic [7:0] NIB_FOUR_BIT   = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0D;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_CURSOR_OFF = 8'h0C;
  localparam logic [7:0] CMD_CGRAM_ADDR = 8'h40;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] DDRAM_LINE2    = 8'h40;
  localparam logic [7:0] CMD_LINE2_HOME = 8'hC0;

  localparam logic [2:0] INIT_LAST_STEP = 3'd6;
  localparam logic [6:0] PERCENT_MAX    = 7'd100;
  localparam logic [4:0] CELLS_MAX      = 5'd16;
  localparam logic [6:0] BAR_FULL       = 7'd5;
  localparam logic [5:0] CURSOR_MAX     = 6'd63;
  localparam logic [7:0] DIV5_RECIP     = 8'd205;

  function automatic kind_t init_kind(input logic [2:0] step);
    kind_t k;
    case (step)
      3'd0, 3'd1, 3'd2, 3'd3: k = KIND_NIBBLE;
      default: k = KIND_CMD;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] init_value(input logic [2:0] step);
    logic [7:0] v;
    case (step)
      3'd0, 3'd1, 3'd2: v = NIB_EIGHT_BIT;
      3'd3: v = NIB_FOUR_BIT;
      3'd4: v = CMD_FUNC_SET;
      3'd5: v = CMD_ENTRY_MODE;
      default: v = CMD_DISP_ON;
    endcase
    return v;
  endfunction

endpackage

/* hdl/lcdseq_ctrl.sv */
// Controller state machine of the character LCD command sequencer.
// Walks each request through its transfers and drives the datapath commands.
// Depends on lcdseq_pkg.
module lcdseq_ctrl
  import lcdseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  op_t        in_operation,
  output logic       in_stall,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = 3'd0;
        if (in_valid) begin
          case (in_operation)
            OP_INIT:        state_nxt = S_INIT;
            OP_CLEAR:       state_nxt = S_CLEAR;
            OP_CURSOR_OFF:  state_nxt = S_OFF;
            OP_GOTO:        state_nxt = S_GOTO;
            OP_PUT_CHAR:    state_nxt = S_CHAR;
            OP_BAR_GRAPH:   state_nxt = S_BAR_MUL;
            OP_CGRAM_START: state_nxt = S_CGRAM_START;
            OP_CGRAM_BYTE:  state_nxt = S_CGRAM_BYTE;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        if (status_i.out_free) begin
          step_nxt = step_r + 3'd1;
          if (step_r == INIT_LAST_STEP) begin
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (status_i.out_free) begin
          state_nxt = S_HOME;
        end
      end
      S_HOME, S_OFF, S_GOTO, S_CHAR_DATA, S_CGRAM_START, S_CGRAM_BYTE: begin
        if (status_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_CHAR: begin
        if (status_i.out_free) begin
          state_nxt = status_i.at_wrap ? S_CHAR_DATA : S_IDLE;
        end
      end
      S_BAR_MUL: state_nxt = S_BAR_DIV;
      S_BAR_DIV: state_nxt = status_i.bar_none ? S_IDLE : S_BAR_CELL;
      S_BAR_CELL: begin
        if (status_i.out_free) begin
          if (status_i.at_wrap) begin
            state_nxt = S_BAR_DATA;
          end else begin
            state_nxt = status_i.bar_more ? S_BAR_CELL : S_IDLE;
          end
        end
      end
      S_BAR_DATA: begin
        if (status_i.out_free) begin
          state_nxt = status_i.bar_more ? S_BAR_CELL : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_req = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.kind     = KIND_CMD;
    cmd_o.vsel     = VSEL_CONST;
    cmd_o.value    = 8'h00;
    cmd_o.last     = 1'b0;
    cmd_o.cur_op   = CUR_HOLD;
    cmd_o.bar_mul  = 1'b0;
    cmd_o.bar_div  = 1'b0;
    cmd_o.bar_step = 1'b0;
    case (state_r)
      S_IDLE: cmd_o.load_req = in_valid;
      S_INIT: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.kind  = init_kind(step_r);
        cmd_o.value = init_value(step_r);
      end
      S_CLEAR: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.value = CMD_CLEAR;
      end
      S_HOME: begin
        cmd_o.emit   = status_i.out_free;
        cmd_o.value  = CMD_DDRAM_ADDR;
        cmd_o.last   = 1'b1;
        cmd_o.cur_op = CUR_ZERO;
      end
      S_OFF: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.value = CMD_CURSOR_OFF;
        cmd_o.last  = 1'b1;
      end
      S_GOTO: begin
        cmd_o.emit   = status_i.out_free;
        cmd_o.vsel   = VSEL_GOTO;
        cmd_o.last   = 1'b1;
        cmd_o.cur_op = CUR_GOTO;
      end
      S_CHAR, S_CHAR_DATA: begin
        cmd_o.emit = status_i.out_free;
        if (state_r == S_CHAR && status_i.at_wrap) begin
          cmd_o.value  = CMD_LINE2_HOME;
          cmd_o.cur_op = CUR_LINE2;
        end else begin
          cmd_o.kind   = KIND_DATA;
          cmd_o.vsel   = VSEL_CODE;
          cmd_o.last   = 1'b1;
          cmd_o.cur_op = CUR_INC;
        end
      end
      S_BAR_MUL: cmd_o.bar_mul = 1'b1;
      S_BAR_DIV: cmd_o.bar_div = 1'b1;
      S_BAR_CELL, S_BAR_DATA: begin
        cmd_o.emit = status_i.out_free;
        if (state_r == S_BAR_CELL && status_i.at_wrap) begin
          cmd_o.value  = CMD_LINE2_HOME;
          cmd_o.cur_op = CUR_LINE2;
        end else begin
          cmd_o.kind     = KIND_DATA;
          cmd_o.vsel     = VSEL_BAR;
          cmd_o.last     = !status_i.bar_more;
          cmd_o.cur_op   = CUR_INC;
          cmd_o.bar_step = status_i.bar_more;
        end
      end
      S_CGRAM_START: begin
        cmd_o.emit  = status_i.out_free;
        cmd_o.value = CMD_CGRAM_ADDR;
        cmd_o.last  = 1'b1;
      end
      S_CGRAM_BYTE: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = KIND_DATA;
        cmd_o.vsel = VSEL_CODE;
        cmd_o.last = 1'b1;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

  // A transfer is never issued while the controller is idle.
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd_o.emit)
    else $error("transfer issued while idle");

  // The final transfer of a request returns the controller to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit && cmd_o.last) |=> (state_r == S_IDLE))
    else $error("controller busy after final transfer");

  // A transfer is only issued when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> status_i.out_free)
    else $error("transfer issued into a full output register");

endmodule

/* hdl/lcdseq_dp.sv */
// Datapath of the character LCD command sequencer.
// Holds the request, cursor position, bar graph arithmetic and the output register.
// Depends on lcdseq_pkg.
module lcdseq_dp
  import lcdseq_pkg::*;
#(
  parameter int LINE_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lcd_req_t   in_data,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall,
  output logic       out_valid,
  output lcd_xfer_t  out_data
);

  localparam logic [5:0] LINE_LEN = 6'(LINE_CHARS);

  lcd_req_t    req_r;
  logic [5:0]  cursor_r, cursor_nxt;
  logic [10:0] prod_r;
  logic [6:0]  v_r;
  logic [4:0]  cells_left_r;
  logic        out_valid_r;
  lcd_xfer_t   out_data_r;

  logic        out_free;
  logic [5:0]  col6, col_c6, goto_x;
  logic        bottom;
  logic [7:0]  goto_value;
  logic [6:0]  goto_pos;
  logic [5:0]  goto_cursor;
  logic [5:0]  cursor_inc;
  logic [6:0]  pct_c;
  logic [4:0]  cells_c;
  logic [16:0] recip_prod;
  logic [7:0]  bar_value;
  logic        bar_more;
  logic [7:0]  xfer_value;

  assign out_free = !out_valid_r || !out_stall;

  assign col6   = {1'b0, req_r.column};
  assign col_c6 = (col6 == 6'd0) ? 6'd1 : ((col6 > LINE_LEN) ? LINE_LEN : col6);
  assign goto_x = col_c6 - 6'd1;
  assign bottom = (req_r.row != 2'd1);
  assign goto_value = CMD_DDRAM_ADDR | (bottom ? DDRAM_LINE2 : 8'h00) | {2'b00, goto_x};
  assign goto_pos = (bottom ? {1'b0, LINE_LEN} : 7'd0) + {1'b0, goto_x};
  assign goto_cursor = (goto_pos > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : goto_pos[5:0];
  assign cursor_inc = (cursor_r == CURSOR_MAX) ? CURSOR_MAX : cursor_r + 6'd1;

  assign pct_c      = (req_r.percent > PERCENT_MAX) ? PERCENT_MAX : req_r.percent;
  assign cells_c    = (req_r.bar_cells > CELLS_MAX) ? CELLS_MAX : req_r.bar_cells;
  // Dividing the product by 20 is a shift by two and a reciprocal multiply for the 5.
  assign recip_prod = 17'(prod_r[10:2]) * 17'(DIV5_RECIP);
  assign bar_more   = (v_r > BAR_FULL) && (cells_left_r > 5'd1);
  assign bar_value  = (v_r > BAR_FULL) ? {1'b0, BAR_FULL} : {1'b0, v_r};

  always_comb begin
    case (cmd_i.vsel)
      VSEL_CONST: xfer_value = cmd_i.value;
      VSEL_GOTO:  xfer_value = goto_value;
      VSEL_CODE:  xfer_value = req_r.char_code;
      VSEL_BAR:   xfer_value = bar_value;
      default:    xfer_value = cmd_i.value;
    endcase
  end

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd_i.emit) begin
      case (cmd_i.cur_op)
        CUR_HOLD:  cursor_nxt = cursor_r;
        CUR_ZERO:  cursor_nxt = 6'd0;
        CUR_GOTO:  cursor_nxt = goto_cursor;
        CUR_LINE2: cursor_nxt = LINE_LEN;
        CUR_INC:   cursor_nxt = cursor_inc;
        default:   cursor_nxt = cursor_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= 6'd0;
      out_valid_r  <= 1'b0;
      v_r          <= 7'd0;
      cells_left_r <= 5'd0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_i.bar_mul) begin
        cells_left_r <= cells_c;
      end else if (cmd_i.emit && cmd_i.bar_step) begin
        cells_left_r <= cells_left_r - 5'd1;
      end
      if (cmd_i.bar_div) begin
        v_r <= recip_prod[16:10];
      end else if (cmd_i.emit && cmd_i.bar_step) begin
        v_r <= v_r - BAR_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_r <= in_data;
    end
    if (cmd_i.bar_mul) begin
      prod_r <= 11'(pct_c) * 11'(cells_c);
    end
    if (cmd_i.emit) begin
      out_data_r.transfer_kind  <= cmd_i.kind;
      out_data_r.transfer_value <= xfer_value;
      out_data_r.last           <= cmd_i.last;
    end
  end

  assign status_o.out_free = out_free;
  assign status_o.at_wrap  = (cursor_r == LINE_LEN);
  assign status_o.bar_none = (cells_left_r == 5'd0);
  assign status_o.bar_more = bar_more;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A line wrap always leaves the cursor at the start of the second line.
  a_wrap_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit && cmd_i.cur_op == CUR_LINE2) |=> (cursor_r == LINE_LEN))
    else $error("cursor not at second line after wrap");

  // The bar graph never spans more than sixteen cells.
  a_cells_range: assert property (@(posedge clk) disable iff (!rst_n)
    cells_left_r <= CELLS_MAX)
    else $error("bar cell count out of range");

  // A bar step only happens while more cells remain and the level exceeds a full cell.
  a_bar_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit && cmd_i.bar_step) |-> (v_r > BAR_FULL && cells_left_r > 5'd1))
    else $error("bar step without remaining level");

endmodule

/* hdl/char_lcd_command_sequencer.sv */
// Top level of the two-line character LCD command sequencer (4-bit bus).
// Joins the controller (lcdseq_ctrl) and the datapath (lcdseq_dp); uses lcdseq_pkg.
//
//   Channel | Ports                            | Payload
//   --------+----------------------------------+-----------------------------
//   request | in_valid, in_stall, in_data      | lcd_req_t (one request)
//   bus     | out_valid, out_stall, out_data   | lcd_xfer_t (one transfer)
//
// A request is taken only while the controller is idle and then emits one transfer per
// cycle through the output register while the bus channel does not stall it.
// A bar graph request first passes through a multiply state and a divide-by-20 state.
// Reset clears the cursor position to zero and returns the controller to idle.
// A stall on the bus channel holds the controller in place until the transaction completes.
module char_lcd_command_sequencer
  import lcdseq_pkg::*;
#(
  parameter int LINE_CHARS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lcd_req_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lcd_xfer_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lcdseq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_stall     (in_stall),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  lcdseq_dp #(
    .LINE_CHARS (LINE_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/char_lcd_command_sequencer_test.sv */
// Testbench for char_lcd_command_sequencer: random and directed requests
// checked against a transfer predictor.
// Depends on lcdseq_pkg for the request and transfer types, the opcodes and the bus constants.
`timescale 1ns / 1ps

module char_lcd_command_sequencer_test;
  import lcdseq_pkg::*;

  localparam int LINE_CHARS     = 16;
  localparam int BAR_DIVISOR    = 20;
  localparam int TOTAL_REQUESTS = 330;
  localparam int DRAIN_CYCLES   = 30;
  localparam int LIMIT_CYCLES   = 300000;
  localparam int MAX_PRINTS     = 40;

  typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  class lcd_bus_tracker;
    lcd_xfer_t expected_xfers[$];
    lcd_xfer_t run_xfers[$];
    int cursor_pos;
    int mismatch_count;
    int checked_count;
    int wrap_count;
    int saturate_count;
    int bar_count;

    function void add_xfer(kind_t kind, logic [7:0] value);
      lcd_xfer_t t;
      t.transfer_kind  = kind;
      t.transfer_value = value;
      t.last           = 1'b0;
      run_xfers.push_back(t);
    endfunction

    function void move_cursor(int pos);
      if (pos > int'(CURSOR_MAX)) begin
        cursor_pos = int'(CURSOR_MAX);
        saturate_count++;
      end else begin
        cursor_pos = pos;
      end
    endfunction

    function void address_cell(int column, int row);
      int col;
      logic [7:0] offset;
      bit bottom;
      col = column;
      if (col < 1) col = 1;
      if (col > LINE_CHARS) col = LINE_CHARS;
      bottom = (row != 1);
      offset = 8'(col - 1);
      add_xfer(KIND_CMD, CMD_DDRAM_ADDR | (bottom ? DDRAM_LINE2 : 8'h00) | offset);
      move_cursor((bottom ? LINE_CHARS : 0) + col - 1);
    endfunction

    function void write_char(logic [7:0] code);
      if (cursor_pos == LINE_CHARS) begin
        address_cell(1, 2);
        wrap_count++;
      end
      add_xfer(KIND_DATA, code);
      move_cursor(cursor_pos + 1);
    endfunction

    function void clear_screen();
      add_xfer(KIND_CMD, CMD_CLEAR);
      address_cell(1, 1);
    endfunction

    function void note_request(lcd_req_t r);
      int level;
      int cells;
      int i;
      bit done;
      case (r.operation)
        OP_INIT: begin
          add_xfer(KIND_NIBBLE, NIB_EIGHT_BIT);
          add_xfer(KIND_NIBBLE, NIB_EIGHT_BIT);
          add_xfer(KIND_NIBBLE, NIB_EIGHT_BIT);
          add_xfer(KIND_NIBBLE, NIB_FOUR_BIT);
          add_xfer(KIND_CMD, CMD_FUNC_SET);
          add_xfer(KIND_CMD, CMD_ENTRY_MODE);
          add_xfer(KIND_CMD, CMD_DISP_ON);
          clear_screen();
        end
        OP_CLEAR: clear_screen();
        OP_CURSOR_OFF: add_xfer(KIND_CMD, CMD_CURSOR_OFF);
        OP_GOTO: address_cell(int'(r.column), int'(r.row));
        OP_PUT_CHAR: write_char(r.char_code);
        OP_BAR_GRAPH: begin
          bar_count++;
          level = (r.percent > PERCENT_MAX) ? int'(PERCENT_MAX) : int'(r.percent);
          cells = (r.bar_cells > CELLS_MAX) ? int'(CELLS_MAX) : int'(r.bar_cells);
          level = level * cells / BAR_DIVISOR;
          done  = 1'b0;
          for (i = 0; i < cells && !done; i++) begin
            if (level > int'(BAR_FULL)) begin
              write_char(8'(BAR_FULL));
              level -= int'(BAR_FULL);
            end else begin
              write_char(level[7:0]);
              done = 1'b1;
            end
          end
        end
        OP_CGRAM_START: add_xfer(KIND_CMD, CMD_CGRAM_ADDR);
        default: add_xfer(KIND_DATA, r.char_code);
      endcase
      for (i = 0; i < run_xfers.size(); i++) begin
        lcd_xfer_t t;
        t      = run_xfers[i];
        t.last = (i == run_xfers.size() - 1);
        expected_xfers.push_back(t);
      end
      run_xfers.delete();
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatch_count < MAX_PRINTS)
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
    endtask

    task check_transfer(lcd_xfer_t got);
      lcd_xfer_t want;
      checked_count++;
      if (expected_xfers.size() == 0) begin
        report_mismatch("transfer with nothing pending", int'(got), 0);
      end else begin
        want = expected_xfers.pop_front();
        if (got.transfer_kind != want.transfer_kind)
          report_mismatch("transfer_kind", int'(got.transfer_kind), int'(want.transfer_kind));
        if (got.transfer_value != want.transfer_value)
          report_mismatch("transfer_value", int'(got.transfer_value),
                          int'(want.transfer_value));
        if (got.last != want.last)
          report_mismatch("last", int'(got.last), int'(want.last));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lcd_req_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lcd_xfer_t out_data;

  lcd_bus_tracker sb;
  int cycle_count;
  int requests_sent;
  int burst_left;
  rx_mode_t rx_mode = RX_FREE;
  int rx_phase_left = 0;
  int rx_run_left = 0;

  char_lcd_command_sequencer #(.LINE_CHARS(LINE_CHARS)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic lcd_req_t random_bits();
    logic [$bits(lcd_req_t)-1:0] raw;
    raw = ($bits(lcd_req_t))'($urandom);
    return raw;
  endfunction

  function automatic lcd_req_t make_req(op_t op, int col, int row, int code, int pct, int cells);
    lcd_req_t r;
    r           = random_bits();
    r.operation = op;
    r.column    = 5'(col);
    r.row       = 2'(row);
    r.char_code = 8'(code);
    r.percent   = 7'(pct);
    r.bar_cells = 5'(cells);
    return r;
  endfunction

  function automatic lcd_req_t random_bar();
    int cells;
    cells = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
    return make_req(OP_BAR_GRAPH, 0, 0, $urandom, $urandom_range(0, 127), cells);
  endfunction

  task send_request(input lcd_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data  <= random_bits();
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    requests_sent++;
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_xfers.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(40, 200);
      out_stall     <= 1'b0;
    end else begin
      rx_phase_left <= rx_phase_left - 1;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (rx_run_left > 0) begin
            rx_run_left <= rx_run_left - 1;
            out_stall   <= 1'b1;
          end else if ($urandom_range(0, 3) == 0) begin
            rx_run_left <= $urandom_range(1, 8);
            out_stall   <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_transfer(out_data);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d transfers pending.",
             cycle_count, sb.expected_xfers.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int choice;
    bit pressure_done;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    burst_left    = 0;
    requests_sent = 0;
    pressure_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: every operation, clamped fields, the line wrap and cursor saturation.
    send_request(make_req(OP_INIT, 0, 0, 0, 0, 0));
    send_request(make_req(OP_CURSOR_OFF, 0, 0, 0, 0, 0));
    send_request(make_req(OP_CGRAM_START, 0, 0, 0, 0, 0));
    send_request(make_req(OP_CGRAM_BYTE, 0, 0, 8'h00, 0, 0));
    send_request(make_req(OP_CGRAM_BYTE, 0, 0, 8'hFF, 0, 0));
    send_request(make_req(OP_GOTO, 0, 0, 0, 0, 0));
    send_request(make_req(OP_GOTO, 31, 3, 0, 0, 0));
    send_request(make_req(OP_GOTO, 17, 1, 0, 0, 0));
    send_request(make_req(OP_PUT_CHAR, 0, 0, 8'hFF, 0, 0));
    send_request(make_req(OP_PUT_CHAR, 0, 0, 8'h00, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
    send_request(make_req(OP_GOTO, 16, 1, 0, 0, 0));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 100, 16));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 127, 31));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 100, 16));
    send_request(make_req(OP_PUT_CHAR, 0, 0, 8'h41, 0, 0));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 0, 1));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 100, 0));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 37, 7));
    send_request(make_req(OP_BAR_GRAPH, 0, 0, 0, 50, 2));
    send_request(make_req(OP_GOTO, 1, 2, 0, 0, 0));
    send_request(make_req(OP_PUT_CHAR, 0, 0, 8'h7E, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 0));

    while (requests_sent < TOTAL_REQUESTS) begin
      if (!pressure_done && requests_sent >= TOTAL_REQUESTS / 2) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      choice = $urandom_range(0, 9);
      if (choice < 6) begin
        // Often position near the end of the top line, then write across it.
        send_request(make_req(OP_GOTO,
                              $urandom_range(0, 1) ? $urandom_range(12, 17) : $urandom_range(0, 31),
                              $urandom_range(0, 1) ? 1 : $urandom_range(0, 3),
                              $urandom, $urandom, $urandom));
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) send_request(random_bar());
          else send_request(make_req(OP_PUT_CHAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        end
      end else if (choice < 9) begin
        send_request(random_bits());
      end else begin
        send_request(make_req($urandom_range(0, 1) ? OP_INIT : OP_CLEAR,
                              $urandom, $urandom, $urandom, $urandom, $urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d bar graphs) and checked %0d bus transfers.",
             requests_sent, sb.bar_count, sb.checked_count);
    $display("Second-line wraps: %0d, saturated cursor moves: %0d, mismatches: %0d.",
             sb.wrap_count, sb.saturate_count, sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.expected_xfers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
